// ----- sv/svm_pkg.sv -----
// Shared types, constants and control store for the supply voltage monitor.
package svm_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int ALPHA_W    = 9;
    localparam int THR_W      = 12;
    localparam int MV_W       = 16;
    localparam int MV_STEPS   = 16;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL   = 3'd6;

    localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_MUL_OLD,
        S_MUL_NEW,
        S_ACC,
        S_DIV_LOAD_F,
        S_DIV_STEP_F,
        S_FILT_STORE,
        S_MUL_MV,
        S_DIV_LOAD_M,
        S_DIV_STEP_M,
        S_OUT
    } step_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_OLD,
        MUL_NEW,
        MUL_MV
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_LOAD_F,
        DIV_LOAD_M,
        DIV_STEP
    } div_op_t;

    typedef enum logic [1:0] {
        FILT_NONE,
        FILT_PRIME,
        FILT_QUO
    } filt_op_t;

    typedef enum logic [2:0] {
        J_NONE,
        J_NO_INPUT,
        J_UNPRIMED,
        J_CNT,
        J_SAT,
        J_OUT_BUSY
    } cond_t;

    typedef struct packed {
        mul_op_t  mul;
        acc_op_t  acc;
        div_op_t  div;
        logic     div_den;
        filt_op_t filt;
        logic     in_rdy;
        logic     out_load;
        cond_t    cond;
        step_t    jump_to;
        step_t    fall_to;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        u = '0;
        case (s)
            S_IDLE:
            begin
                u.in_rdy  = 1'b1;
                u.cond    = J_NO_INPUT;
                u.jump_to = S_IDLE;
                u.fall_to = S_PRIME;
            end
            S_PRIME:
            begin
                u.filt    = FILT_PRIME;
                u.cond    = J_UNPRIMED;
                u.jump_to = S_MUL_MV;
                u.fall_to = S_MUL_OLD;
            end
            S_MUL_OLD:
            begin
                u.mul     = MUL_OLD;
                u.fall_to = S_MUL_NEW;
            end
            S_MUL_NEW:
            begin
                u.mul     = MUL_NEW;
                u.acc     = ACC_LOAD;
                u.fall_to = S_ACC;
            end
            S_ACC:
            begin
                u.acc     = ACC_ADD;
                u.fall_to = S_DIV_LOAD_F;
            end
            S_DIV_LOAD_F:
            begin
                u.div     = DIV_LOAD_F;
                u.fall_to = S_DIV_STEP_F;
            end
            S_DIV_STEP_F:
            begin
                u.div     = DIV_STEP;
                u.cond    = J_CNT;
                u.jump_to = S_DIV_STEP_F;
                u.fall_to = S_FILT_STORE;
            end
            S_FILT_STORE:
            begin
                u.filt    = FILT_QUO;
                u.fall_to = S_MUL_MV;
            end
            S_MUL_MV:
            begin
                u.mul     = MUL_MV;
                u.fall_to = S_DIV_LOAD_M;
            end
            S_DIV_LOAD_M:
            begin
                u.div     = DIV_LOAD_M;
                u.div_den = 1'b1;
                u.cond    = J_SAT;
                u.jump_to = S_OUT;
                u.fall_to = S_DIV_STEP_M;
            end
            S_DIV_STEP_M:
            begin
                u.div     = DIV_STEP;
                u.div_den = 1'b1;
                u.cond    = J_CNT;
                u.jump_to = S_DIV_STEP_M;
                u.fall_to = S_OUT;
            end
            S_OUT:
            begin
                u.out_load = 1'b1;
                u.cond     = J_OUT_BUSY;
                u.jump_to  = S_OUT;
                u.fall_to  = S_IDLE;
            end
            default:
            begin
                u.fall_to = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- sv/supply_voltage_monitor.sv -----
// Supply voltage monitor: microcoded IIR low-pass filter, mV scaling and supply health check.
// The sequencer takes one sample at a time and accepts the next only after loading the result.
// The first sample after reset only primes the filter and skips the filter divide, and a
// saturated mV estimate skips the mV divide.
// The shared restoring divider produces one quotient bit per cycle; a stalled result holds.
// Reset: filter unprimed and zero, config registers at defaults, no output pending.
module supply_voltage_monitor
    import svm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            raw_sample,
    input  logic                   sample_valid,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] raw_used,
    output logic [SAMPLE_BITS-1:0] filtered_value,
    output logic [MV_W-1:0]        voltage_mv,
    output logic                   cal_ok,
    output logic                   uncalibrated,
    output logic                   adc_ok,
    output logic                   supply_good
);

    localparam int ACC_W    = SAMPLE_BITS + 8;
    localparam int QUO_PAD  = MV_W - SAMPLE_BITS;

    // configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] denom_reg;
    logic [MV_W-1:0]    num_reg;
    logic [MV_W-1:0]    den_reg;
    logic [THR_W-1:0]   thr_reg;
    logic               guard_reg;
    logic               cal_reg;

    // sequencer and filter state
    step_t                  step_reg, step_next;
    logic                   primed_reg, primed_next;
    logic [SAMPLE_BITS-1:0] filt_reg, filt_next;
    logic                   out_valid_reg, out_valid_next;

    // datapath
    logic [SAMPLE_BITS-1:0] used_reg, used_next;
    logic                   ok_reg, ok_next;
    logic [2*MV_W-1:0]      prod_reg, prod_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [MV_W-1:0]        rem_reg, rem_next;
    logic [MV_W-1:0]        quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   sat_reg, sat_next;

    // output holding register
    logic [SAMPLE_BITS-1:0] raw_used_reg, raw_used_next;
    logic [SAMPLE_BITS-1:0] filt_out_reg, filt_out_next;
    logic [MV_W-1:0]        mv_reg, mv_next;
    logic                   cal_out_reg, cal_out_next;
    logic                   adc_ok_reg, adc_ok_next;
    logic                   pg_reg, pg_next;

    ucode_t             uc;
    logic               take;
    logic               out_busy;
    logic               in_fire;
    logic [ALPHA_W-1:0] denom_eff;
    logic [ALPHA_W-1:0] alpha_eff;
    logic [MV_W-1:0]    mul_a;
    logic [MV_W-1:0]    mul_b;
    logic [MV_W-1:0]    divisor;
    logic [MV_W:0]      rem_shift;
    logic [MV_W:0]      rem_sub;
    logic               fits;
    logic               sat_now;
    logic               sample_ok;

    always_comb
    begin
        uc        = ucode_rom(step_reg);
        out_busy  = out_valid_reg && !out_ready;
        in_fire   = in_valid && uc.in_rdy;
        denom_eff = (denom_reg == '0) ? ALPHA_W'(1) : denom_reg;
        alpha_eff = (alpha_reg > denom_eff) ? denom_eff : alpha_reg;
        sat_now   = prod_reg[2*MV_W-1:MV_W] >= den_reg;
        sample_ok = sample_valid && ((raw_sample >> SAMPLE_BITS) == 16'd0);

        case (uc.cond)
            J_NONE:     take = 1'b0;
            J_NO_INPUT: take = !in_valid;
            J_UNPRIMED: take = !primed_reg;
            J_CNT:      take = cnt_reg != '0;
            J_SAT:      take = sat_now;
            J_OUT_BUSY: take = out_busy;
            default:    take = 1'b0;
        endcase
        step_next = take ? uc.jump_to : uc.fall_to;

        // latch the incoming sample
        used_next = used_reg;
        ok_next   = ok_reg;
        if (in_fire)
        begin
            ok_next   = sample_ok;
            used_next = sample_ok ? raw_sample[SAMPLE_BITS-1:0] : '0;
        end

        // shared multiplier
        case (uc.mul)
            MUL_OLD:
            begin
                mul_a = MV_W'(filt_reg);
                mul_b = MV_W'(alpha_eff);
            end
            MUL_NEW:
            begin
                mul_a = MV_W'(used_reg);
                mul_b = MV_W'(denom_eff - alpha_eff);
            end
            MUL_MV:
            begin
                mul_a = MV_W'(filt_reg);
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = (uc.mul == MUL_NONE) ? prod_reg : (2*MV_W)'(mul_a) * (2*MV_W)'(mul_b);

        case (uc.acc)
            ACC_LOAD: acc_next = prod_reg[ACC_W-1:0];
            ACC_ADD:  acc_next = acc_reg + prod_reg[ACC_W-1:0];
            default:  acc_next = acc_reg;
        endcase

        // restoring divider, one quotient bit per step
        divisor   = uc.div_den ? den_reg : MV_W'(denom_eff);
        rem_shift = {rem_reg, quo_reg[MV_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor};
        fits      = rem_shift >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        case (uc.div)
            DIV_LOAD_F:
            begin
                // high part is already below the divisor, so only the low bits iterate
                rem_next = MV_W'(acc_reg[ACC_W-1:SAMPLE_BITS]);
                quo_next = MV_W'(acc_reg[SAMPLE_BITS-1:0]) << QUO_PAD;
                cnt_next = CNT_W'(SAMPLE_BITS - 1);
            end
            DIV_LOAD_M:
            begin
                rem_next = prod_reg[2*MV_W-1:MV_W];
                quo_next = prod_reg[MV_W-1:0];
                cnt_next = CNT_W'(MV_STEPS - 1);
                sat_next = sat_now;
            end
            DIV_STEP:
            begin
                rem_next = fits ? rem_sub[MV_W-1:0] : rem_shift[MV_W-1:0];
                quo_next = {quo_reg[MV_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase

        filt_next   = filt_reg;
        primed_next = primed_reg;
        case (uc.filt)
            FILT_PRIME:
            begin
                if (!primed_reg)
                begin
                    filt_next   = used_reg;
                    primed_next = 1'b1;
                end
            end
            FILT_QUO:
            begin
                filt_next = quo_reg[SAMPLE_BITS-1:0];
            end
            default:
            begin
                filt_next = filt_reg;
            end
        endcase

        // output register: hold while a result waits, drop it once taken
        out_valid_next = out_valid_reg && !out_ready;
        raw_used_next  = raw_used_reg;
        filt_out_next  = filt_out_reg;
        mv_next        = mv_reg;
        cal_out_next   = cal_out_reg;
        adc_ok_next    = adc_ok_reg;
        pg_next        = pg_reg;
        if (uc.out_load && !out_busy)
        begin
            out_valid_next = 1'b1;
            raw_used_next  = used_reg;
            filt_out_next  = filt_reg;
            cal_out_next   = cal_reg;
            adc_ok_next    = ok_reg;
            if (!cal_reg || den_reg == '0)
                mv_next = '0;
            else if (sat_reg)
                mv_next = MV_MAX;
            else
                mv_next = quo_reg;
            if (!guard_reg)
                pg_next = 1'b1;
            else if (!ok_reg)
                pg_next = 1'b0;
            else
                pg_next = MV_W'(filt_reg) >= MV_W'(thr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            primed_reg    <= 1'b0;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
            alpha_reg     <= ALPHA_W'(7);
            denom_reg     <= ALPHA_W'(8);
            num_reg       <= MV_W'(1);
            den_reg       <= MV_W'(1);
            thr_reg       <= '0;
            guard_reg     <= 1'b1;
            cal_reg       <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            primed_reg    <= primed_next;
            filt_reg      <= filt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                    CFG_DENOM: denom_reg <= cfg_data[ALPHA_W-1:0];
                    CFG_NUM:   num_reg   <= cfg_data;
                    CFG_DEN:   den_reg   <= cfg_data;
                    CFG_THR:   thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_GUARD: guard_reg <= cfg_data[0];
                    CFG_CAL:   cal_reg   <= cfg_data[0];
                    default:   guard_reg <= guard_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg     <= used_next;
        ok_reg       <= ok_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        sat_reg      <= sat_next;
        raw_used_reg <= raw_used_next;
        filt_out_reg <= filt_out_next;
        mv_reg       <= mv_next;
        cal_out_reg  <= cal_out_next;
        adc_ok_reg   <= adc_ok_next;
        pg_reg       <= pg_next;
    end

    assign in_ready       = uc.in_rdy;
    assign out_valid      = out_valid_reg;
    assign raw_used       = raw_used_reg;
    assign filtered_value = filt_out_reg;
    assign voltage_mv     = mv_reg;
    assign cal_ok         = cal_out_reg;
    assign uncalibrated   = !cal_out_reg;
    assign adc_ok         = adc_ok_reg;
    assign supply_good    = pg_reg;

    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("filter lost its primed state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == S_PRIME))
        else $error("sequencer did not start after an input transaction");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !adc_ok) |-> (raw_used == '0))
        else $error("rejected sample reported as nonzero");

    a_uncal_zero_mv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && uncalibrated) |-> (voltage_mv == '0))
        else $error("uncalibrated result carries a voltage");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !uc.out_load)
        else $error("input accepted while a result is being loaded");

endmodule

// ----- verif/supply_voltage_monitor_tb.sv -----
// Self-checking testbench for the supply voltage monitor: IIR filter, mV scaling, health flag.
module supply_voltage_monitor_tb;
    import svm_pkg::*;

    localparam int SAMPLE_BITS   = 12;
    localparam int SETTLE_CYCLES = SAMPLE_BITS + 30;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 100;

    // alpha, denom, num, den, threshold, guard, calibration
    localparam int PRESETS [6][7] = '{
        '{0,   256, 65535, 1,     4095, 1, 1},
        '{256, 256, 1,     65535, 0,    0, 1},
        '{200, 100, 1000,  0,     2048, 1, 1},
        '{5,   0,   65535, 65535, 1,    1, 0},
        '{1,   1,   0,     1,     4095, 0, 1},
        '{3,   4,   3300,  4096,  2000, 1, 1}
    };

    // {sample_valid, raw_sample}
    localparam logic [16:0] EDGE_SAMPLES [18] = '{
        {1'b1, 16'hFFFF}, {1'b1, 16'h0FFF}, {1'b1, 16'h0000}, {1'b1, 16'h1000},
        {1'b0, 16'h0FFF}, {1'b0, 16'hFFFF}, {1'b1, 16'h8000}, {1'b1, 16'h0800},
        {1'b1, 16'h0001}, {1'b1, 16'h0AAA}, {1'b1, 16'h0555}, {1'b1, 16'h5555},
        {1'b1, 16'hAAAA}, {1'b0, 16'h0000}, {1'b1, 16'h0FFF}, {1'b1, 16'h0FFF},
        {1'b1, 16'h0FFF}, {1'b1, 16'h0FFE}
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw_used;
        logic [SAMPLE_BITS-1:0] filtered;
        logic [MV_W-1:0]        mv;
        logic                   cal_ok;
        logic                   uncal;
        logic                   adc_ok;
        logic                   pgood;
    } reading_t;

    class supply_check;
        logic [ALPHA_W-1:0]     alpha = 9'd7;
        logic [ALPHA_W-1:0]     denom = 9'd8;
        logic [MV_W-1:0]        num   = 16'd1;
        logic [MV_W-1:0]        den   = 16'd1;
        logic [THR_W-1:0]       thr   = '0;
        logic                   guard = 1'b1;
        logic                   cal   = 1'b0;
        logic                   primed = 1'b0;
        logic [SAMPLE_BITS-1:0] level  = '0;
        reading_t               readings_due[$];
        int                     mismatches = 0;
        int                     checked    = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALPHA: alpha = data[ALPHA_W-1:0];
                CFG_DENOM: denom = data[ALPHA_W-1:0];
                CFG_NUM:   num   = data[MV_W-1:0];
                CFG_DEN:   den   = data[MV_W-1:0];
                CFG_THR:   thr   = data[THR_W-1:0];
                CFG_GUARD: guard = data[0];
                CFG_CAL:   cal   = data[0];
                default:   ;
            endcase
        endfunction

        function void note_sample(logic [15:0] raw, logic flag);
            reading_t        r;
            logic            ok;
            int unsigned     d;
            int unsigned     a;
            longint unsigned mv;
            ok = flag && (raw < (1 << SAMPLE_BITS));
            r.raw_used = ok ? raw[SAMPLE_BITS-1:0] : '0;
            // zero denominator acts as one; alpha clamps to the denominator
            d = (denom == 0) ? 1 : denom;
            a = (alpha > d) ? d : alpha;
            if (!primed)
            begin
                primed = 1'b1;
                level  = r.raw_used;
            end
            else
            begin
                level = SAMPLE_BITS'((level * a + r.raw_used * (d - a)) / d);
            end
            mv = 0;
            if (cal && den != 0)
            begin
                mv = 64'(level);
                mv = mv * num / den;
                if (mv > MV_MAX)
                    mv = 64'(MV_MAX);
            end
            r.filtered = level;
            r.mv       = mv[MV_W-1:0];
            r.cal_ok   = cal;
            r.uncal    = !cal;
            r.adc_ok   = ok;
            r.pgood    = !guard ? 1'b1 : (ok && level >= thr);
            readings_due.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (readings_due.size() == 0)
            begin
                $error("result with no sample outstanding (filtered_value %0d)", got.filtered);
                mismatches++;
                return;
            end
            want = readings_due.pop_front();
            checked++;
            match_field("raw_used", want.raw_used, got.raw_used);
            match_field("filtered_value", want.filtered, got.filtered);
            match_field("voltage_mv", want.mv, got.mv);
            match_field("cal_ok", want.cal_ok, got.cal_ok);
            match_field("uncalibrated", want.uncal, got.uncal);
            match_field("adc_ok", want.adc_ok, got.adc_ok);
            match_field("supply_good", want.pgood, got.pgood);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [15:0]            raw_sample   = '0;
    logic                   sample_valid = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [SAMPLE_BITS-1:0] raw_used;
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic [MV_W-1:0]        voltage_mv;
    logic                   cal_ok;
    logic                   uncalibrated;
    logic                   adc_ok;
    logic                   supply_good;

    supply_check sb = new;

    bit          idle_on       = 1'b1;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    int          samples_sent  = 0;
    int          settings_used = 0;
    int          burst_left    = 0;
    logic [15:0] burst_raw     = '0;

    supply_voltage_monitor #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_sample    (raw_sample),
        .sample_valid  (sample_valid),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_used      (raw_used),
        .filtered_value(filtered_value),
        .voltage_mv    (voltage_mv),
        .cal_ok        (cal_ok),
        .uncalibrated  (uncalibrated),
        .adc_ok        (adc_ok),
        .supply_good   (supply_good)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic int unsigned biased(int unsigned lo, int unsigned hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results outstanding", sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: start stalls at random so they land on every phase of the work
    always @(posedge clk)
    begin
        if (hold_left == 0 && $urandom_range(0, 7) == 0)
            hold_left = pick_gap();
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_sample(raw_sample, sample_valid);
    end

    always @(posedge clk)
    begin : result_mon
        reading_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.raw_used = raw_used;
            got.filtered = filtered_value;
            got.mv       = voltage_mv;
            got.cal_ok   = cal_ok;
            got.uncal    = uncalibrated;
            got.adc_ok   = adc_ok;
            got.pgood    = supply_good;
            sb.check_reading(got);
        end
    end

    // leaves valid high after the transaction when no gap follows
    task automatic send_sample(input logic [15:0] raw, input logic flag);
        int gap;
        in_valid     <= 1'b1;
        raw_sample   <= raw;
        sample_valid <= flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.write_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_setting(input int unsigned alpha, input int unsigned denom,
                                 input int unsigned num, input int unsigned den,
                                 input int unsigned thr, input int unsigned guard,
                                 input int unsigned cal);
        put_reg(CFG_ALPHA, alpha);
        put_reg(CFG_DENOM, denom);
        put_reg(CFG_NUM, num);
        put_reg(CFG_DEN, den);
        put_reg(CFG_THR, thr);
        put_reg(CFG_GUARD, guard);
        put_reg(CFG_CAL, cal);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly in-range readings, with runs of a steady level so the filter settles
    task automatic next_random_sample(output logic [15:0] raw, output logic flag);
        int r;
        if (burst_left == 0 && $urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            burst_raw  = 16'($urandom_range(0, 4095));
        end
        if (burst_left != 0)
        begin
            burst_left--;
            raw  = burst_raw;
            flag = 1'b1;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            raw  = 16'($urandom_range(0, 4095));
            flag = 1'b1;
        end
        else if (r < 78)
        begin
            raw  = 16'($urandom());
            flag = 1'b0;
        end
        else if (r < 88)
        begin
            raw  = 16'($urandom_range(4096, 65535));
            flag = 1'b1;
        end
        else if (r < 94)
        begin
            case ($urandom_range(0, 3))
                0:       raw = 16'h0000;
                1:       raw = 16'h0FFF;
                2:       raw = 16'h1000;
                default: raw = 16'hFFFF;
            endcase
            flag = 1'b1;
        end
        else
        begin
            raw  = 16'($urandom());
            flag = 1'($urandom_range(0, 1));
        end
    endtask

    initial
    begin
        logic [15:0] raw;
        logic        flag;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, uncalibrated; an out-of-range first sample primes the filter at zero
        foreach (EDGE_SAMPLES[i])
            send_sample(EDGE_SAMPLES[i][15:0], EDGE_SAMPLES[i][16]);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (2) @(posedge clk);
            if (p < 6)
                apply_setting(PRESETS[p][0], PRESETS[p][1], PRESETS[p][2], PRESETS[p][3],
                              PRESETS[p][4], PRESETS[p][5], PRESETS[p][6]);
            else
                apply_setting(biased(0, 256), biased(0, 256), biased(0, 65535),
                              biased(0, 65535), biased(0, 4095),
                              $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            idle_on = (p % 4 != 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                next_random_sample(raw, flag);
                send_sample(raw, flag);
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d samples under %0d register settings", samples_sent,
                 settings_used);
        $display("%0d readings checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
